>>> design/utcep_pkg.sv
// Shared types, constants and tables for the UTC date to epoch seconds converter.
`timescale 1ns / 1ps
package utcep_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int EPOCH_W = 36;
    localparam int DAYS_W  = 20;
    localparam int TSEC_W  = 17;
    localparam int QY_W    = 10;
    localparam int QC_W    = 6;
    localparam int RECIP_W = 12;
    localparam int RECIP_SH = 16;
    localparam int DOM_W   = 9;
    localparam int SPD_W   = 17;

    localparam int NSTAGE  = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;

    // 1/25 scaled by 2^16, exact for quotients of values below 2^12
    localparam logic [RECIP_W-1:0] RECIP_25 = 12'd2622;
    localparam logic [QC_W-1:0]    CENT_DIV = 6'd25;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR         = 12'd1970;
    localparam logic [DAYS_W-1:0]  LEAPS_BEFORE_EPOCH = 20'd477;
    localparam logic [8:0]         DAYS_PER_YEAR      = 9'd365;
    localparam logic [SPD_W-1:0]   SECS_PER_DAY       = 17'd86400;
    localparam logic [TSEC_W-1:0]  SECS_PER_HOUR      = 17'd3600;
    localparam logic [TSEC_W-1:0]  SECS_PER_MIN       = 17'd60;

    localparam logic               RST_PRESENT   = 1'b0;
    localparam logic [YEAR_W-1:0]  RST_MIN_YEAR  = 12'd2020;
    localparam logic [EPOCH_W-1:0] RST_MIN_EPOCH = 36'd1577836800;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENT   = 2'd0,
        CFG_MIN_YEAR  = 2'd1,
        CFG_MIN_EPOCH = 2'd2
    } utcep_cfg_idx_t;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } utcep_ctrl_t;

    function automatic logic [DOM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOM_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> design/utcep_datapath.sv
// Five-stage datapath: date checks and time of day, day count, day scaling, time add, final check.
`timescale 1ns / 1ps
module utcep_datapath import utcep_pkg::*; (
    input  logic                aclk,
    input  utcep_ctrl_t         ctrl,
    input  logic                present,
    input  logic [YEAR_W-1:0]   min_year,
    input  logic [EPOCH_W-1:0]  min_epoch,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    input  logic [DAY_W-1:0]    day,
    input  logic [HOUR_W-1:0]   hour,
    input  logic [MIN_W-1:0]    minute,
    input  logic [SEC_W-1:0]    second,
    output logic [EPOCH_W-1:0]  epoch_seconds,
    output logic                valid_res
);

    // stage 1
    logic                      s1_ok_reg;
    logic [YEAR_W-1:0]         s1_year_reg;
    logic [MONTH_W-1:0]        s1_month_reg;
    logic [DAY_W-1:0]          s1_day_reg;
    logic [TSEC_W-1:0]         s1_tsec_reg;
    logic [QY_W-1:0]           s1_pq_reg;
    logic [QC_W-1:0]           s1_pc_reg;
    logic [QY_W-1:0]           s1_yq_reg;
    logic [QC_W-1:0]           s1_yc_reg;

    logic                      ok_next;
    logic [YEAR_W-1:0]         prev_year;
    logic [QY_W-1:0]           pq;
    logic [QY_W-1:0]           yq;
    logic [QY_W+RECIP_W-1:0]   pq_prod;
    logic [QY_W+RECIP_W-1:0]   yq_prod;
    logic [TSEC_W-1:0]         tsec_next;

    always_comb begin
        ok_next   = present && (year >= min_year) && (month >= MONTH_JAN) &&
                    (month <= MONTH_DEC) && (day >= DAY_FIRST);
        prev_year = year - 12'd1;
        pq        = prev_year[YEAR_W-1:2];
        yq        = year[YEAR_W-1:2];
        pq_prod   = (QY_W+RECIP_W)'(pq) * (QY_W+RECIP_W)'(RECIP_25);
        yq_prod   = (QY_W+RECIP_W)'(yq) * (QY_W+RECIP_W)'(RECIP_25);
        tsec_next = TSEC_W'(hour) * SECS_PER_HOUR + TSEC_W'(minute) * SECS_PER_MIN
                    + TSEC_W'(second);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            s1_ok_reg    <= ok_next;
            s1_year_reg  <= year;
            s1_month_reg <= month;
            s1_day_reg   <= day;
            s1_tsec_reg  <= tsec_next;
            s1_pq_reg    <= pq;
            s1_pc_reg    <= pq_prod[RECIP_SH +: QC_W];
            s1_yq_reg    <= yq;
            s1_yc_reg    <= yq_prod[RECIP_SH +: QC_W];
        end
    end

    // stage 2: day count
    logic                s2_ok_reg;
    logic [DAYS_W-1:0]   s2_days_reg;
    logic [TSEC_W-1:0]   s2_tsec_reg;

    logic                century;
    logic                leap;
    logic [DAYS_W-1:0]   year_days;
    logic [DAYS_W-1:0]   days_next;

    always_comb begin
        century = (s1_year_reg[1:0] == 2'd0) &&
                  ((QY_W+1)'(s1_yq_reg) == (QY_W+1)'(s1_yc_reg) * (QY_W+1)'(CENT_DIV));
        leap    = (s1_year_reg[1:0] == 2'd0) && (!century || (s1_yc_reg[1:0] == 2'd0));
        if (s1_year_reg > EPOCH_YEAR) begin
            year_days = DAYS_W'(s1_year_reg - EPOCH_YEAR) * DAYS_W'(DAYS_PER_YEAR)
                        + DAYS_W'(s1_pq_reg) - DAYS_W'(s1_pc_reg)
                        + DAYS_W'(s1_pc_reg[QC_W-1:2]) - LEAPS_BEFORE_EPOCH;
        end else begin
            year_days = '0;
        end
        days_next = year_days + DAYS_W'(days_before_month(s1_month_reg))
                    + DAYS_W'(leap && (s1_month_reg > MONTH_FEB))
                    + DAYS_W'(s1_day_reg) - DAYS_W'(DAY_FIRST);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            s2_ok_reg   <= s1_ok_reg;
            s2_days_reg <= days_next;
            s2_tsec_reg <= s1_tsec_reg;
        end
    end

    // stage 3: days to seconds
    logic                s3_ok_reg;
    logic [EPOCH_W-1:0]  s3_prod_reg;
    logic [TSEC_W-1:0]   s3_tsec_reg;
    logic [DAYS_W+SPD_W-1:0] day_prod;

    assign day_prod = (DAYS_W+SPD_W)'(s2_days_reg) * (DAYS_W+SPD_W)'(SECS_PER_DAY);

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            s3_ok_reg   <= s2_ok_reg;
            s3_prod_reg <= day_prod[EPOCH_W-1:0];
            s3_tsec_reg <= s2_tsec_reg;
        end
    end

    // stage 4: add time of day
    logic                s4_ok_reg;
    logic [EPOCH_W-1:0]  s4_sum_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            s4_ok_reg  <= s3_ok_reg;
            s4_sum_reg <= s3_prod_reg + EPOCH_W'(s3_tsec_reg);
        end
    end

    // stage 5: output register
    logic                out_valid_reg;
    logic [EPOCH_W-1:0]  out_epoch_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            out_epoch_reg <= s4_ok_reg ? s4_sum_reg : '0;
            out_valid_reg <= s4_ok_reg && (s4_sum_reg >= min_epoch);
        end
    end

    assign epoch_seconds = out_epoch_reg;
    assign valid_res     = out_valid_reg;

endmodule

>>> design/utc_date_to_epoch_seconds.sv
// Top level: Gregorian UTC date to Unix epoch seconds with a validity flag.
// Each input transfer passes every pipeline stage register before its result is on m_tdata/m_tuser.
// Throughput: one transfer per cycle; each stage holds under back-pressure
// and fills bubbles, so nothing is dropped or repeated.
// Reset (aresetn low, synchronous): pipeline emptied, present = 0,
// min_year = 2020, min_epoch = 1577836800.
`timescale 1ns / 1ps
module utc_date_to_epoch_seconds import utcep_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], second[37:32]
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // epoch_seconds[35:0]
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // valid_res[0]
    output logic                    m_tuser,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [EPOCH_W-1:0]      cfg_data
);

    logic                present_reg;
    logic [YEAR_W-1:0]   min_year_reg;
    logic [EPOCH_W-1:0]  min_epoch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg   <= RST_PRESENT;
            min_year_reg  <= RST_MIN_YEAR;
            min_epoch_reg <= RST_MIN_EPOCH;
        end else if (cfg_wr_en) begin
            case (utcep_cfg_idx_t'(cfg_index))
                CFG_PRESENT:   present_reg   <= cfg_data[0];
                CFG_MIN_YEAR:  min_year_reg  <= cfg_data[YEAR_W-1:0];
                CFG_MIN_EPOCH: min_epoch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage occupancy and per-stage ready
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] rdy;

    always_comb begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next = valid_reg;
        if (rdy[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    utcep_ctrl_t         ctrl;
    logic [EPOCH_W-1:0]  epoch_seconds;
    logic                valid_res;

    assign ctrl.load = rdy;

    utcep_datapath u_datapath (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .present       (present_reg),
        .min_year      (min_year_reg),
        .min_epoch     (min_epoch_reg),
        .year          (s_tdata[11:0]),
        .month         (s_tdata[15:12]),
        .day           (s_tdata[20:16]),
        .hour          (s_tdata[25:21]),
        .minute        (s_tdata[31:26]),
        .second        (s_tdata[37:32]),
        .epoch_seconds (epoch_seconds),
        .valid_res     (valid_res)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = OUT_TDATA_W'(epoch_seconds);
    assign m_tuser  = valid_res;

endmodule
